### hdl/shs_pkg.sv
package shs_pkg;

  // default sizing
  localparam int TABLE_SLOTS_DEF = 101;
  localparam int PROBE_LIMIT_DEF = 20;
  localparam int KEY_BYTES_DEF   = 15;

  // fixed field widths
  localparam int KEY_BYTES_MAX = 15;
  localparam int LOW_W         = 64;
  localparam int HIGH_W        = 56;
  localparam int KEY_W         = LOW_W + HIGH_W;
  localparam int FUNC_W        = 2;
  localparam int SEL_W         = 7;
  localparam int STATUS_W      = 3;
  localparam int USED_W        = 7;
  localparam int TOTAL_W       = 7;

  // stream packing
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_PAD_W  = OUT_DATA_W - (USED_W + TOTAL_W + LOW_W + HIGH_W);

  // hash arithmetic
  localparam int SUM_W        = 15;   // 255 * (1 + ... + 15) fits
  localparam int HASH_W       = 20;   // 19 * max sum fits
  localparam int HASH_MULT    = 19;
  localparam int PROBE_LINEAR = 23;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_READ     = 3'd6
  } status_t;

  typedef struct packed {
    logic done;
    logic empty_key;
  } hash_stat_t;

endpackage

### hdl/shs_ram.sv
module shs_ram #(
  parameter int WIDTH = shs_pkg::KEY_W,
  parameter int DEPTH = shs_pkg::TABLE_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/shs_hash.sv
// Byte-serial key normalizer and home-slot hash.
// One key byte per cycle, then 19*sum reduced mod TABLE_SLOTS by reciprocal
// multiply with a single correction step.
module shs_hash #(
  parameter int TABLE_SLOTS = shs_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = shs_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [shs_pkg::LOW_W-1:0]      key_low,
  input  logic [shs_pkg::HIGH_W-1:0]     key_high,
  output shs_pkg::hash_stat_t            stat,
  output logic [$clog2(TABLE_SLOTS)-1:0] home,
  output logic [shs_pkg::LOW_W-1:0]      norm_low,
  output logic [shs_pkg::HIGH_W-1:0]     norm_high
);

  localparam int AW     = $clog2(TABLE_SLOTS);
  localparam int HW     = shs_pkg::HASH_W;
  localparam int PROD_W = 2 * HW;
  localparam int NB     = shs_pkg::KEY_BYTES_MAX;
  localparam int SW     = shs_pkg::SUM_W;

  localparam logic [HW-1:0] RECIP    = HW'((1 << HW) / TABLE_SLOTS);
  localparam logic [HW-1:0] NMOD     = HW'(TABLE_SLOTS);
  localparam logic [HW-1:0] MULT     = HW'(shs_pkg::HASH_MULT);
  localparam logic [3:0]    LAST_IDX = 4'(KEY_BYTES - 1);

  typedef enum logic [2:0] {
    H_IDLE,
    H_SCAN,
    H_SCALE,
    H_RECIP,
    H_BACK,
    H_FIX
  } hstate_t;

  hstate_t               hstate_r, hstate_nxt;
  logic [NB-1:0][7:0]    key_r, key_nxt;
  logic [NB-1:0][7:0]    raw_bytes;
  logic [3:0]            idx_r, idx_nxt;
  logic                  alive_r, alive_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [HW-1:0]         x_r, x_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [HW-1:0]         qn_r, qn_nxt;
  logic [AW-1:0]         home_r, home_nxt;
  logic                  done_r, done_nxt;

  logic [7:0]            cur_b;
  logic [3:0]            wgt;
  logic [11:0]           term;
  logic [HW-1:0]         rem;

  assign raw_bytes = {key_high, key_low};
  assign cur_b     = key_r[idx_r];
  assign wgt       = idx_r + 4'd1;
  assign term      = 12'(cur_b) * 12'(wgt);
  assign rem       = x_r - qn_r;

  always_comb begin
    hstate_nxt = hstate_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    alive_nxt  = alive_r;
    sum_nxt    = sum_r;
    x_nxt      = x_r;
    prod_nxt   = prod_r;
    qn_nxt     = qn_r;
    home_nxt   = home_r;
    done_nxt   = 1'b0;

    case (hstate_r)
      H_IDLE: begin
        if (start) begin
          for (int i = 0; i < NB; i++) begin
            key_nxt[i] = (i < KEY_BYTES) ? raw_bytes[i] : 8'h00;
          end
          idx_nxt    = 4'd0;
          alive_nxt  = 1'b1;
          sum_nxt    = '0;
          hstate_nxt = H_SCAN;
        end
      end
      H_SCAN: begin
        // first zero byte ends the key; everything after it is cleared
        if (!alive_r || cur_b == 8'h00) begin
          alive_nxt      = 1'b0;
          key_nxt[idx_r] = 8'h00;
        end else begin
          sum_nxt = sum_r + SW'(term);
        end
        if (idx_r == LAST_IDX) begin
          hstate_nxt = H_SCALE;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      H_SCALE: begin
        x_nxt      = HW'(sum_r) * MULT;
        hstate_nxt = H_RECIP;
      end
      H_RECIP: begin
        prod_nxt   = PROD_W'(x_r) * PROD_W'(RECIP);
        hstate_nxt = H_BACK;
      end
      H_BACK: begin
        // quotient estimate is exact or one low
        qn_nxt     = prod_r[PROD_W-1:HW] * NMOD;
        hstate_nxt = H_FIX;
      end
      H_FIX: begin
        home_nxt   = (rem >= NMOD) ? AW'(rem - NMOD) : AW'(rem);
        done_nxt   = 1'b1;
        hstate_nxt = H_IDLE;
      end
      default: begin
        hstate_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstate_r <= H_IDLE;
      done_r   <= 1'b0;
    end else begin
      hstate_r <= hstate_nxt;
      done_r   <= done_nxt;
    end
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    alive_r <= alive_nxt;
    sum_r   <= sum_nxt;
    x_r     <= x_nxt;
    prod_r  <= prod_nxt;
    qn_r    <= qn_nxt;
    home_r  <= home_nxt;
  end

  assign stat.done      = done_r;
  assign stat.empty_key = (key_r[0] == 8'h00);
  assign home           = home_r;
  assign norm_low       = key_r[7:0];
  assign norm_high      = key_r[NB-1:8];

endmodule

### hdl/string_key_hash_set_unit.sv
// Channel   Dir  Handshake           Payload
// --------  ---  ------------------  ------------------------------------------------
// in_       in   in_tvalid/tready    tuser: func; tdata: key_low, key_high, slot_select
// out_      out  out_tvalid/tready   tuser: status; tdata: slot_used, entry_total,
//                                    read_low, read_high
//
// Insert/remove time is set by the byte-serial hash and by one slot read per probe
// from the single table RAM. Clear writes one RAM row per cycle.
// After reset a clearing pass over every table slot runs before in_tready rises.
// One transaction is worked at a time; the result register lets the next input
// be taken while a result waits, and a held result stalls only the final commit.
module string_key_hash_set_unit #(
  parameter int TABLE_SLOTS = shs_pkg::TABLE_SLOTS_DEF,
  parameter int PROBE_LIMIT = shs_pkg::PROBE_LIMIT_DEF,
  parameter int KEY_BYTES   = shs_pkg::KEY_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] key_low, [119:64] key_high, [126:120] slot_select, [127] zero
  input  logic [shs_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] func
  input  logic [shs_pkg::FUNC_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [6:0] slot_used, [13:7] entry_total, [77:14] read_low, [133:78] read_high,
  // [135:134] zero
  output logic [shs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] status
  output logic [shs_pkg::STATUS_W-1:0]      out_tuser
);

  localparam int AW    = $clog2(TABLE_SLOTS);
  localparam int CW    = $clog2(TABLE_SLOTS + 1);
  localparam int JW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int SW    = shs_pkg::SEL_W;
  localparam int CMP_W = ((SW > AW) ? SW : AW) + 1;
  localparam int LW    = shs_pkg::LOW_W;
  localparam int HW    = shs_pkg::HIGH_W;
  localparam int KW    = shs_pkg::KEY_W;

  localparam logic [AW:0]   NSUM       = (AW + 1)'(TABLE_SLOTS);
  localparam logic [AW-1:0] STEP0      = AW'((shs_pkg::PROBE_LINEAR + 1) % TABLE_SLOTS);
  localparam logic [AW-1:0] STEP_INC   = AW'(2 % TABLE_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(TABLE_SLOTS - 1);
  localparam logic [JW-1:0] LAST_PROBE = JW'(PROBE_LIMIT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_LAST,
    S_RDISSUE,
    S_RDDATA,
    S_DONE
  } state_t;

  // input fields
  shs_pkg::func_t   in_func;
  logic [LW-1:0]    in_key_low;
  logic [HW-1:0]    in_key_high;
  logic [SW-1:0]    in_sel;

  // control
  state_t            state_r, state_nxt;
  shs_pkg::func_t    func_r, func_nxt;
  logic [SW-1:0]     sel_r, sel_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              clr_report_r, clr_report_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // probe walk
  logic [AW-1:0]     p_r, p_nxt;
  logic [AW-1:0]     dm_r, dm_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [AW-1:0]     slot_d_r, slot_d_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     found_slot_r, found_slot_nxt;
  logic              free_r, free_nxt;
  logic [AW-1:0]     free_slot_r, free_slot_nxt;
  logic [LW-1:0]     rdl_r, rdl_nxt;
  logic [HW-1:0]     rdh_r, rdh_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  shs_pkg::status_t          out_status_r, out_status_nxt;
  logic [shs_pkg::USED_W-1:0]  out_used_r, out_used_nxt;
  logic [shs_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [LW-1:0]             out_low_r, out_low_nxt;
  logic [HW-1:0]             out_high_r, out_high_nxt;

  // table RAM and hash unit
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [KW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [KW-1:0]     mem_rdata;
  logic              hash_start;
  shs_pkg::hash_stat_t hstat;
  logic [AW-1:0]     hash_home;
  logic [LW-1:0]     norm_low;
  logic [HW-1:0]     norm_high;

  // datapath helpers
  logic [LW-1:0]     rd_low;
  logic [HW-1:0]     rd_high;
  logic              key_hit;
  logic              slot_free;
  logic [AW:0]       p_sum;
  logic [AW-1:0]     p_adv;
  logic [AW:0]       d_sum;
  logic [AW-1:0]     d_adv;
  logic              sel_in_range;
  logic              out_free;

  assign in_func     = shs_pkg::func_t'(in_tuser);
  assign in_key_low  = in_tdata[LW-1:0];
  assign in_key_high = in_tdata[KW-1:LW];
  assign in_sel      = in_tdata[KW+SW-1:KW];

  shs_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  shs_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (hash_start),
    .key_low   (in_key_low),
    .key_high  (in_key_high),
    .stat      (hstat),
    .home      (hash_home),
    .norm_low  (norm_low),
    .norm_high (norm_high)
  );

  assign rd_low  = mem_rdata[LW-1:0];
  assign rd_high = mem_rdata[KW-1:LW];
  // stored keys are never empty, so a match implies an occupied slot
  assign key_hit   = (rd_low == norm_low) && (rd_high == norm_high);
  assign slot_free = (rd_low[7:0] == 8'h00);

  // next probe: p += 2j+24 mod N, with the step itself kept mod N
  assign p_sum = {1'b0, p_r} + {1'b0, dm_r};
  assign p_adv = (p_sum >= NSUM) ? AW'(p_sum - NSUM) : p_sum[AW-1:0];
  assign d_sum = {1'b0, dm_r} + {1'b0, STEP_INC};
  assign d_adv = (d_sum >= NSUM) ? AW'(d_sum - NSUM) : d_sum[AW-1:0];

  assign sel_in_range = CMP_W'(sel_r) < CMP_W'(TABLE_SLOTS);
  assign out_free     = !out_valid_r || out_tready;
  assign in_tready    = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    sel_nxt        = sel_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    dm_nxt         = dm_r;
    j_nxt          = j_r;
    slot_d_nxt     = slot_d_r;
    cmp_vld_nxt    = (state_r == S_PROBE);
    found_nxt      = found_r;
    found_slot_nxt = found_slot_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    rdl_nxt        = rdl_r;
    rdh_nxt        = rdh_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    out_total_nxt  = out_total_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = '0;
    mem_raddr      = p_r;
    hash_start     = 1'b0;

    // data for the probe issued last cycle; keep the first hit and first hole
    if (cmp_vld_r) begin
      if (!found_r && key_hit) begin
        found_nxt      = 1'b1;
        found_slot_nxt = slot_d_r;
      end
      if (!free_r && slot_free) begin
        free_nxt      = 1'b1;
        free_slot_nxt = slot_d_r;
      end
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == LAST_SLOT) begin
          clr_addr_nxt   = '0;
          count_nxt      = '0;
          clr_report_nxt = 1'b0;
          state_nxt      = clr_report_r ? S_DONE : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_func;
          sel_nxt   = in_sel;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          case (in_func)
            shs_pkg::FUNC_INSERT,
            shs_pkg::FUNC_REMOVE: begin
              hash_start = 1'b1;
              state_nxt  = S_HASH;
            end
            shs_pkg::FUNC_CLEAR: begin
              clr_addr_nxt   = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = S_CLEAR;
            end
            shs_pkg::FUNC_READ: begin
              state_nxt = S_RDISSUE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (hstat.done) begin
          p_nxt     = hash_home;
          dm_nxt    = STEP0;
          j_nxt     = '0;
          state_nxt = hstat.empty_key ? S_DONE : S_PROBE;
        end
      end
      S_PROBE: begin
        mem_raddr  = p_r;
        slot_d_nxt = p_r;
        p_nxt      = p_adv;
        dm_nxt     = d_adv;
        if (j_r == LAST_PROBE) begin
          state_nxt = S_LAST;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_RDISSUE: begin
        mem_raddr = AW'(sel_r);
        state_nxt = S_RDDATA;
      end
      S_RDDATA: begin
        if (sel_in_range && !slot_free) begin
          rdl_nxt = rd_low;
          rdh_nxt = rd_high;
        end else begin
          rdl_nxt = '0;
          rdh_nxt = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // commit table change and result together once the result slot is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_used_nxt  = '0;
          out_low_nxt   = '0;
          out_high_nxt  = '0;
          case (func_r)
            shs_pkg::FUNC_INSERT: begin
              if (found_r) begin
                out_status_nxt = shs_pkg::ST_PRESENT;
                out_used_nxt   = shs_pkg::USED_W'(found_slot_r);
              end else if (hstat.empty_key) begin
                out_status_nxt = shs_pkg::ST_PRESENT;
              end else if (free_r) begin
                mem_we         = 1'b1;
                mem_waddr      = free_slot_r;
                mem_wdata      = {norm_high, norm_low};
                count_nxt      = count_r + 1'b1;
                out_status_nxt = shs_pkg::ST_INSERTED;
                out_used_nxt   = shs_pkg::USED_W'(free_slot_r);
              end else begin
                out_status_nxt = shs_pkg::ST_FULL;
              end
            end
            shs_pkg::FUNC_REMOVE: begin
              if (found_r) begin
                mem_we    = 1'b1;
                mem_waddr = found_slot_r;
                mem_wdata = '0;
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
                out_status_nxt = shs_pkg::ST_REMOVED;
                out_used_nxt   = shs_pkg::USED_W'(found_slot_r);
              end else begin
                out_status_nxt = shs_pkg::ST_ABSENT;
              end
            end
            shs_pkg::FUNC_CLEAR: begin
              out_status_nxt = shs_pkg::ST_CLEARED;
            end
            shs_pkg::FUNC_READ: begin
              out_status_nxt = shs_pkg::ST_READ;
              out_used_nxt   = sel_r;
              out_low_nxt    = rdl_r;
              out_high_nxt   = rdh_r;
            end
            default: begin
              out_status_nxt = shs_pkg::ST_ABSENT;
            end
          endcase
          out_total_nxt = shs_pkg::TOTAL_W'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      count_r      <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      count_r      <= count_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      free_r       <= free_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    sel_r        <= sel_nxt;
    p_r          <= p_nxt;
    dm_r         <= dm_nxt;
    j_r          <= j_nxt;
    slot_d_r     <= slot_d_nxt;
    found_slot_r <= found_slot_nxt;
    free_slot_r  <= free_slot_nxt;
    rdl_r        <= rdl_nxt;
    rdh_r        <= rdh_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
    out_total_r  <= out_total_nxt;
    out_low_r    <= out_low_nxt;
    out_high_r   <= out_high_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{shs_pkg::OUT_PAD_W{1'b0}}, out_high_r, out_low_r,
                       out_total_r, out_used_r};

`ifndef SYNTHESIS
  // key count can never pass the table size
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_SLOTS))
    else $error("key count above table size");

  // probe reads never overlap a table write
  a_no_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_LAST || state_r == S_RDDATA) |-> !mem_we)
    else $error("table write during probe or read");

  // hash completion only while the controller waits for it
  a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    hstat.done |-> (state_r == S_HASH))
    else $error("hash done outside hash wait");

  // an accepted transaction always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted input left controller idle");

  // a result is committed only into a free result register
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result committed over a held result");
`endif

endmodule

### tb/tb_string_key_hash_set_unit.sv
module tb_string_key_hash_set_unit;
  import shs_pkg::*;

  localparam int NUM_SLOTS    = TABLE_SLOTS_DEF;
  localparam int NUM_PROBES   = PROBE_LIMIT_DEF;
  localparam int RANDOM_OPS   = 1560;
  localparam int DRAIN_CYCLES = TABLE_SLOTS_DEF + 64;
  localparam int HOLD_CYCLES  = 700;

  // Two-byte keys whose weighted byte sum is fixed all share one home slot
  // (sum 200 -> home 63), so enough of them fill every probe position.
  localparam int FAMILY_SUM   = 200;
  localparam int FAMILY_SUM_B = 250;

  // out_tdata field offsets, lowest bit first
  localparam int OUT_TOTAL_LSB = USED_W;
  localparam int OUT_LOW_LSB   = USED_W + TOTAL_W;
  localparam int OUT_HIGH_LSB  = OUT_LOW_LSB + LOW_W;

  // one input transaction; key is {key_high, key_low}, byte i at [8i+7:8i]
  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [SEL_W-1:0]   sel;
  } hash_op_t;

  // one result transaction; key is {read_high, read_low}
  typedef struct packed {
    status_t            status;
    logic [USED_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
    logic [KEY_W-1:0]   key;
  } hash_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // stimulus and scoreboard
  hash_op_t         pending_ops[$];
  hash_reply_t      awaited_results[$];
  logic [KEY_W-1:0] key_pool[$];
  int               err_cnt = 0;
  logic             in_took = 1'b0;

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key[NUM_SLOTS];
  int               shadow_total = 0;

  // sender burst / gap state
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall state
  int rx_cycle = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  string_key_hash_set_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Truncates the key at its first zero byte and returns the home slot.
  function automatic int key_home(input logic [KEY_W-1:0] raw,
                                  output logic [KEY_W-1:0] norm);
    int sum;
    bit ended;
    sum = 0;
    ended = 1'b0;
    norm = '0;
    for (int i = 0; i < KEY_BYTES_DEF; i++) begin
      if (raw[8*i +: 8] == 8'd0) ended = 1'b1;
      if (!ended) begin
        sum += int'(raw[8*i +: 8]) * (i + 1);
        norm[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return (HASH_MULT * sum) % NUM_SLOTS;
  endfunction

  function automatic int probe_at(input int home, input int j);
    return (home + j * j + PROBE_LINEAR * j) % NUM_SLOTS;
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  function automatic hash_reply_t hash_set_result(input hash_op_t op);
    hash_reply_t r;
    logic [KEY_W-1:0] norm;
    int home;
    int hit;
    int s;
    r.status = ST_READ;
    r.slot   = '0;
    r.key    = '0;
    case (op.func)
      FUNC_INSERT, FUNC_REMOVE: begin
        home = key_home(op.key, norm);
        hit = -1;
        // holes do not end the search: every probe position is looked at
        if (norm[7:0] != 8'd0) begin
          for (int j = 0; j < NUM_PROBES; j++) begin
            s = probe_at(home, j);
            if (hit < 0 && shadow_key[s][7:0] != 8'd0 && shadow_key[s] == norm) hit = s;
          end
        end
        if (op.func == FUNC_INSERT) begin
          if (norm[7:0] == 8'd0) begin
            r.status = ST_PRESENT;            // empty key, nothing done
          end else if (hit >= 0) begin
            r.status = ST_PRESENT;
            r.slot   = hit[USED_W-1:0];
          end else begin
            r.status = ST_FULL;
            for (int j = 0; j < NUM_PROBES; j++) begin
              s = probe_at(home, j);
              if (r.status == ST_FULL && shadow_key[s][7:0] == 8'd0) begin
                shadow_key[s] = norm;
                shadow_total++;
                r.status = ST_INSERTED;
                r.slot   = s[USED_W-1:0];
              end
            end
          end
        end else if (hit >= 0) begin
          shadow_key[hit] = '0;
          if (shadow_total > 0) shadow_total--;
          r.status = ST_REMOVED;
          r.slot   = hit[USED_W-1:0];
        end else begin
          r.status = ST_ABSENT;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) shadow_key[i] = '0;
        shadow_total = 0;
        r.status = ST_CLEARED;
      end
      default: begin
        // out-of-range slot reads as empty but still echoes the slot number
        r.status = ST_READ;
        r.slot   = op.sel;
        if (op.sel < NUM_SLOTS && shadow_key[op.sel][7:0] != 8'd0) r.key = shadow_key[op.sel];
      end
    endcase
    r.total = shadow_total[TOTAL_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Unused fields carry random junk: key bits on reads, slot number otherwise.
  function automatic void queue_op(input func_t f, input logic [KEY_W-1:0] k,
                                   input logic [SEL_W-1:0] s);
    hash_op_t op;
    if (f == FUNC_READ) k = KEY_W'({$urandom, $urandom, $urandom, $urandom});
    else s = SEL_W'($urandom_range(127));
    op.func = f;
    op.key  = k;
    op.sel  = s;
    pending_ops.push_back(op);
  endfunction

  // len nonzero bytes, then a zero byte if len is below the key width; junk after the terminator if asked.
  function automatic logic [KEY_W-1:0] make_key(input int len, input bit junk);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < KEY_BYTES_DEF; i++) begin
      if (i < len) k[8*i +: 8] = 8'($urandom_range(255, 1));
      else if (junk && i > len) k[8*i +: 8] = 8'($urandom_range(255));
    end
    return k;
  endfunction

  // Two-byte key with b0 + 2*b1 == sum, so all members share a home slot.
  function automatic logic [KEY_W-1:0] family_key(input int sum, input int b1,
                                                  input bit junk);
    logic [KEY_W-1:0] k;
    k = '0;
    if (junk) k = KEY_W'({$urandom, $urandom, $urandom, $urandom});
    k[7:0]   = 8'(sum - 2 * b1);
    k[15:8]  = 8'(b1);
    k[23:16] = 8'd0;
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transaction per burst slot, held until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drv
    hash_op_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_tvalid) begin
        // last offer was taken; end of burst opens a random gap
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(12, 1);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 1);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur = pending_ops.pop_front();
        in_tdata  <= {1'b0, cur.sel, cur.key};
        in_tuser  <= cur.func;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall modes plus two long hold-offs that back the block
  // up until in_tready drops
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_cycle == 4000 || rx_cycle == 50000) begin
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(2);
          mode_left = $urandom_range(400, 30);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(1));
          default: out_tready <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transactions, check on result transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    hash_op_t    op;
    hash_reply_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with none expected: status %0d", out_tuser);
          err_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            err_cnt++;
          end
          if (out_tdata[USED_W-1:0] !== want.slot) begin
            $error("slot_used: expected %0d, actual %0d", want.slot, out_tdata[USED_W-1:0]);
            err_cnt++;
          end
          if (out_tdata[OUT_TOTAL_LSB +: TOTAL_W] !== want.total) begin
            $error("entry_total: expected %0d, actual %0d", want.total,
                   out_tdata[OUT_TOTAL_LSB +: TOTAL_W]);
            err_cnt++;
          end
          if (out_tdata[OUT_LOW_LSB +: LOW_W] !== want.key[LOW_W-1:0]) begin
            $error("read_low: expected %h, actual %h", want.key[LOW_W-1:0],
                   out_tdata[OUT_LOW_LSB +: LOW_W]);
            err_cnt++;
          end
          if (out_tdata[OUT_HIGH_LSB +: HIGH_W] !== want.key[KEY_W-1:LOW_W]) begin
            $error("read_high: expected %h, actual %h", want.key[KEY_W-1:LOW_W],
                   out_tdata[OUT_HIGH_LSB +: HIGH_W]);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        op.func = func_t'(in_tuser);
        op.key  = in_tdata[KEY_W-1:0];
        op.sel  = in_tdata[KEY_W +: SEL_W];
        awaited_results.push_back(hash_set_result(op));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [KEY_W-1:0] k;
    int pick;
    for (int i = 0; i < NUM_SLOTS; i++) shadow_key[i] = '0;

    // directed: extremes, normalization, empty key, out-of-range reads
    queue_op(FUNC_READ, '0, 7'd0);
    queue_op(FUNC_INSERT, {KEY_W{1'b1}}, '0);                 // full-length 0xFF key
    queue_op(FUNC_INSERT, {KEY_W{1'b1}}, '0);                 // already there
    queue_op(FUNC_INSERT, {96'hDEAD_BEEF_0123_4567_89AB_CDEF, 24'h00_42_41}, '0);
    queue_op(FUNC_INSERT, 120'h4241, '0);                     // same key once trimmed
    queue_op(FUNC_INSERT, {{112{1'b1}}, 8'h00}, '0);          // empty key with junk
    queue_op(FUNC_REMOVE, {{112{1'b1}}, 8'h00}, '0);
    queue_op(FUNC_REMOVE, 120'h5A, '0);                       // never inserted
    queue_op(FUNC_READ, '0, 7'd100);
    queue_op(FUNC_READ, '0, 7'd101);
    queue_op(FUNC_READ, '0, 7'd127);
    queue_op(FUNC_REMOVE, {KEY_W{1'b1}}, '0);
    queue_op(FUNC_REMOVE, {KEY_W{1'b1}}, '0);
    queue_op(FUNC_CLEAR, '0, '0);
    // one home slot: 20 keys fill every probe position, the 21st is dropped
    for (int n = 1; n <= NUM_PROBES + 1; n++)
      queue_op(FUNC_INSERT, family_key(FAMILY_SUM, n, (n % 3) == 0), '0);
    queue_op(FUNC_INSERT, family_key(FAMILY_SUM, 5, 1'b0), '0);
    queue_op(FUNC_REMOVE, family_key(FAMILY_SUM, 10, 1'b1), '0);
    queue_op(FUNC_INSERT, family_key(FAMILY_SUM, NUM_PROBES + 2, 1'b0), '0);  // fills hole
    queue_op(FUNC_READ, '0, 7'd63);

    // random: mostly inserts/removes over a recycled key pool and two
    // colliding families, so probe chains fill up; clears are rare
    for (int i = 0; i < RANDOM_OPS; i++) begin
      pick = $urandom_range(999);
      if (pick < 5) begin
        queue_op(FUNC_CLEAR, '0, '0);
      end else if (pick < 200) begin
        queue_op(FUNC_READ, '0, SEL_W'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                                : $urandom_range(100)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 40 && key_pool.size() > 0)
          k = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (pick < 70)
          k = family_key(($urandom_range(4) == 0) ? FAMILY_SUM_B : FAMILY_SUM,
                         $urandom_range(99, 1), 1'($urandom_range(1)));
        else if (pick < 97)
          k = make_key($urandom_range(KEY_BYTES_DEF, 1), 1'($urandom_range(1)));
        else
          k = make_key(0, 1'b1);
        if (pick >= 40) begin
          key_pool.push_back(k);
          if (key_pool.size() > 48) void'(key_pool.pop_front());
        end
        queue_op(($urandom_range(99) < 60) ? FUNC_INSERT : FUNC_REMOVE, k, '0);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // all offered, then all answered, then a quiet stretch for strays
    while (pending_ops.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, well above the slowest legal run
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### string_key_hash_set_unit.f
hdl/shs_pkg.sv
hdl/shs_ram.sv
hdl/shs_hash.sv
hdl/string_key_hash_set_unit.sv
tb/tb_string_key_hash_set_unit.sv
